### rtl/core/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID step unit package
// Shared types, widths and codes for the PID step unit.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int BAND_W    = 31;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT   = 3'd0,
      CSR_PROP_GAIN  = 3'd1,
      CSR_INTEG_GAIN = 3'd2,
      CSR_DERIV_GAIN = 3'd3,
      CSR_INTEG_BAND = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] measurement;
      logic        [DATA_W-1:0] elapsed_time;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] control_out;
      logic signed [DATA_W-1:0] prop_term;
      logic signed [DATA_W-1:0] integ_term;
      logic signed [DATA_W-1:0] deriv_term;
      logic                     zero_dt_flag;
      logic                     saturated_flag;
   } rsp_payload_type;

   // Serial multiply: 34 x 34 bit signed operands, one bit a cycle.
   localparam int MUL_W   = 34;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int MCNT_W  = 6;
   // Serial divide: 50-bit dividend magnitude, one quotient bit a cycle.
   localparam int DIVN_W  = DATA_W + 1 + FRAC_BITS + 1;
   localparam int DCNT_W  = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_PMUL,
      ST_AMUL,
      ST_IMUL,
      ST_IACC,
      ST_DIV,
      ST_DMUL,
      ST_SUM,
      ST_OUT
   } seq_state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v,
                                                      output logic clip);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(signed'(32'sh7fffffff));
      lo = PROD_W'(signed'(32'sh80000000));
      clip = 1'b0;
      if (v > hi) begin
         clip = 1'b1;
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         clip = 1'b1;
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

### rtl/core/pidc_mul.sv
// ----------------------------------------------------------------------------
// PID serial multiplier
// Signed shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidc_mul import pidc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic                     done,
   output logic signed [PROD_W-1:0] product
);

   logic              busy_ff, busy_in;
   logic [MCNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [MUL_W-1:0]  mplr_ff, mplr_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic              done_ff, done_in;

   // Operands are two's complement; sign-extended to the product width the
   // shift-and-add gives the exact product modulo 2^PROD_W.
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         acc_in   = '0;
         mplr_in  = op_b;
         mcand_in = PROD_W'(op_a);
      end else if (busy_ff) begin
         if (mplr_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mplr_in  = {mplr_ff[MUL_W-1], mplr_ff[MUL_W-1:1]};
         mcand_in = {mcand_ff[PROD_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == MCNT_W'(MUL_W - 1)) begin
            // Last bit carries negative weight.
            if (mplr_ff[0]) begin
               acc_in = acc_ff - mcand_ff;
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff   <= acc_in;
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = signed'(acc_ff);

endmodule

### rtl/core/pidc_div.sv
// ----------------------------------------------------------------------------
// PID serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div import pidc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVN_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DIVN_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVN_W-1:0] quo_ff, quo_in;
   logic [DATA_W:0]   rem_ff, rem_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [DATA_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         trial = {rem_ff[DATA_W-1:0], quo_ff[DIVN_W-1]};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIVN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/pid_controller_step_unit.sv
// ----------------------------------------------------------------------------
// PID controller step unit
// Trapezoidal-integral PID step in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// One item is worked at a time. An item's work is four passes of the
// bit-serial 34-bit multiplier (P, trapezoid area, I and D), one pass of the
// bit-serial 50-bit divider for the error rate, and the sequencing steps
// ERR, IACC, SUM and OUT. With a zero elapsed time the divide and the D
// multiply are skipped; with the error outside the band the area and I
// multiplies and the integral update are skipped; with both, all of these
// are skipped. A new item is taken only in the idle state, once the result
// register has been handed on or is empty.
module pid_controller_step_unit import pidc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload
);

   logic signed [DATA_W-1:0] setpoint_ff, prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [BAND_W-1:0]        integ_band_ff;
   logic signed [DATA_W-1:0] last_error_ff, integral_acc_ff;

   seq_state_type state_ff, state_in;

   logic signed [DATA_W-1:0] meas_ff;
   logic [DATA_W-1:0]        dt_ff;
   logic signed [DATA_W-1:0] err_ff, pterm_ff, dterm_ff;
   logic                     clip_ff, inband_ff, neg_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_ff;

   logic                     mul_start, div_start;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic                     mul_done, div_done;
   logic signed [PROD_W-1:0] mul_p;
   logic [DIVN_W-1:0]        div_n, div_q;

   logic                     accept;

   // Combinational helpers.
   logic signed [PROD_W-1:0] err_wide, diff_wide, sum_wide;
   logic signed [PROD_W-1:0] prod_sh, area_s, rate_s;
   logic [PROD_W-1:0]        area_q;
   logic signed [DATA_W-1:0] err_sat, sat_prod, area_sat, rate_sat, integ_sat, sum_sat;
   logic                     err_clip, prod_clip, area_clip, rate_clip, integ_clip, sum_clip;
   logic signed [DATA_W+1:0] band_s, trap_s;
   logic [DATA_W:0]          trap_mag;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);

   pidc_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(mul_p)
   );

   pidc_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_n), .divisor(dt_ff), .done(div_done), .quotient(div_q)
   );

   assign err_wide  = PROD_W'(setpoint_ff) - PROD_W'(meas_ff);
   assign band_s    = (DATA_W+2)'({1'b0, integ_band_ff});
   assign trap_s    = (DATA_W+2)'(last_error_ff) + (DATA_W+2)'(err_ff);
   assign trap_mag  = trap_s[DATA_W+1] ? (DATA_W+1)'(-trap_s) : trap_s[DATA_W:0];
   assign diff_wide = PROD_W'(err_ff) - PROD_W'(last_error_ff);
   assign sum_wide  = PROD_W'(pterm_ff) + PROD_W'(integral_acc_ff) + PROD_W'(dterm_ff);

   // Saturation of every stage, ready in the cycle its unit finishes so that
   // the next multiply can start on it straight away.
   always_comb begin
      err_sat  = sat32(err_wide, err_clip);
      prod_sh  = mul_p >>> FRAC_BITS;
      sat_prod = sat32(prod_sh, prod_clip);
      // Floor of signed area: ceil of magnitude when negative.
      area_q = unsigned'(mul_p) >> (FRAC_BITS + 1);
      if (neg_ff && (mul_p[FRAC_BITS:0] != '0)) area_q = area_q + 1'b1;
      area_s   = neg_ff ? -signed'(area_q) : signed'(area_q);
      area_sat = sat32(area_s, area_clip);
      rate_s   = diff_wide[PROD_W-1] ? -signed'(PROD_W'(div_q)) : signed'(PROD_W'(div_q));
      rate_sat = sat32(rate_s, rate_clip);
      integ_sat = sat32(acc_ff, integ_clip);
      sum_sat   = sat32(sum_wide, sum_clip);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_ERR;
         ST_ERR:  state_in = ST_PMUL;
         ST_PMUL: if (mul_done) state_in = inband_ff ? ST_AMUL :
                                           ((dt_ff == '0) ? ST_SUM : ST_DIV);
         ST_AMUL: if (mul_done) state_in = ST_IMUL;
         ST_IMUL: if (mul_done) state_in = ST_IACC;
         ST_IACC: state_in = (dt_ff == '0) ? ST_SUM : ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_DMUL;
         ST_DMUL: if (mul_done) state_in = ST_SUM;
         ST_SUM:  state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Unit start pulses on entry to each step.
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_n     = '0;
      if (state_ff != state_in) begin
         case (state_in)
            ST_PMUL: begin
               mul_start = 1'b1;
               mul_a = MUL_W'(prop_gain_ff);
               mul_b = MUL_W'(err_sat);
            end
            ST_AMUL: begin
               mul_start = 1'b1;
               mul_a = MUL_W'({1'b0, trap_mag});
               mul_b = MUL_W'({1'b0, dt_ff});
            end
            ST_IMUL: begin
               mul_start = 1'b1;
               mul_a = MUL_W'(integ_gain_ff);
               mul_b = MUL_W'(area_sat);
            end
            ST_DIV: begin
               div_start = 1'b1;
               div_n = DIVN_W'((diff_wide[PROD_W-1] ? -diff_wide : diff_wide)
                               <<< FRAC_BITS);
            end
            ST_DMUL: begin
               mul_start = 1'b1;
               mul_a = MUL_W'(deriv_gain_ff);
               mul_b = MUL_W'(rate_sat);
            end
            default: begin
               mul_start = 1'b0;
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         setpoint_ff     <= '0;
         prop_gain_ff    <= '0;
         integ_gain_ff   <= '0;
         deriv_gain_ff   <= '0;
         integ_band_ff   <= BAND_W'(3 << FRAC_BITS);
         last_error_ff   <= '0;
         integral_acc_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SETPOINT:   setpoint_ff   <= csr_write_data;
               CSR_PROP_GAIN:  prop_gain_ff  <= csr_write_data;
               CSR_INTEG_GAIN: integ_gain_ff <= csr_write_data;
               CSR_DERIV_GAIN: deriv_gain_ff <= csr_write_data;
               CSR_INTEG_BAND: integ_band_ff <= csr_write_data[BAND_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (accept) begin
               meas_ff <= req_payload.measurement;
               dt_ff   <= req_payload.elapsed_time;
               clip_ff <= 1'b0;
               dterm_ff <= '0;
            end
            ST_ERR: begin
               err_ff    <= err_sat;
               clip_ff   <= err_clip;
               inband_ff <= ((DATA_W+2)'(err_sat) > -band_s) &&
                            ((DATA_W+2)'(err_sat) < band_s);
            end
            ST_PMUL: if (mul_done) begin
               pterm_ff <= sat_prod;
               clip_ff  <= clip_ff | prod_clip;
               neg_ff   <= trap_s[DATA_W+1];
            end
            ST_AMUL: if (mul_done) begin
               clip_ff <= clip_ff | area_clip;
            end
            ST_IMUL: if (mul_done) begin
               acc_ff  <= PROD_W'(integral_acc_ff) + PROD_W'(sat_prod);
               clip_ff <= clip_ff | prod_clip;
            end
            ST_IACC: if (inband_ff) begin
               integral_acc_ff <= integ_sat;
               clip_ff <= clip_ff | integ_clip;
            end
            ST_DIV: if (div_done) begin
               clip_ff <= clip_ff | rate_clip;
            end
            ST_DMUL: if (mul_done) begin
               dterm_ff <= sat_prod;
               clip_ff  <= clip_ff | prod_clip;
            end
            ST_SUM: begin
               rsp_ff.control_out    <= sum_sat;
               rsp_ff.prop_term      <= pterm_ff;
               rsp_ff.integ_term     <= integral_acc_ff;
               rsp_ff.deriv_term     <= dterm_ff;
               rsp_ff.zero_dt_flag   <= (dt_ff == '0);
               rsp_ff.saturated_flag <= clip_ff | sum_clip;
               last_error_ff         <= err_ff;
            end
            ST_OUT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/pidc_checker.sv
// ----------------------------------------------------------------------------
// PID step unit checker
// Port-level checks on the PID step unit, bound to the top level.
// ----------------------------------------------------------------------------
module pidc_checker import pidc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // Once an item is taken, the unit is busy on the very next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("unit took an item without becoming busy");

   // A result cannot appear in the cycle after an item was taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared too early");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   // With a zero elapsed time the D term is zero.
   a_zero_dt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.zero_dt_flag) |-> (rsp_payload.deriv_term == '0))
      else $error("D term not zero with zero elapsed time");

endmodule

bind pid_controller_step_unit pidc_checker u_pidc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
);
